>>> rtl/core/lcdnw_pkg.sv
// Shared types and constants for the character LCD nibble writer.
// Used by the front classifier, the command queue, the strobe sequencer and the top level.
package lcdnw_pkg;

    typedef enum logic [1:0] {
        OP_DATA   = 2'd0,
        OP_INSTR  = 2'd1,
        OP_CURSOR = 2'd2,
        OP_INIT   = 2'd3
    } op_t;

    localparam logic [1:0] CFG_STROBE   = 2'd0;
    localparam logic [1:0] CFG_SETTLE   = 2'd1;
    localparam logic [1:0] CFG_POWER_UP = 2'd2;

    localparam logic [7:0] STROBE_RESET   = 8'd1;
    localparam logic [7:0] SETTLE_RESET   = 8'd2;
    localparam logic [7:0] POWER_UP_RESET = 8'd30;

    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
    localparam int         ROW_SHIFT     = 6;

    localparam int         QUEUE_DEPTH = 4;
    localparam int         QUEUE_AW    = 2;
    localparam int         QUEUE_CW    = 3;

    localparam logic [2:0] INIT_LAST_STEP = 3'd6;

    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic       full;
        logic [7:0] code;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic [8:0] after_ms;
        logic [7:0] pulse_ms;
        logic [7:0] lead_ms;
        logic [3:0] nibble;
        logic       reg_select;
    } strobe_t;

    function automatic logic [3:0] init_nibble(input logic [2:0] step);
        logic [3:0] nib;
        unique case (step)
            3'd0:    nib = 4'h2;
            3'd1:    nib = 4'h2;
            3'd2:    nib = 4'h8;
            3'd3:    nib = 4'h0;
            3'd4:    nib = 4'hC;
            3'd5:    nib = 4'h0;
            3'd6:    nib = 4'h1;
            default: nib = 4'h0;
        endcase
        return nib;
    endfunction

    function automatic logic [1:0] init_extra(input logic [2:0] step);
        logic [1:0] extra;
        unique case (step)
            3'd2:    extra = 2'd1;
            3'd4:    extra = 2'd1;
            3'd6:    extra = 2'd2;
            default: extra = 2'd0;
        endcase
        return extra;
    endfunction

endpackage

>>> rtl/core/lcdnw_front.sv
// Front classifier: turns a request into a queued command and tracks init_done.
// Depends on lcdnw_pkg.
module lcdnw_front #(
    parameter int ROWS    = 2,
    parameter int COLUMNS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic [1:0]           operation,
    input  logic [7:0]           value,
    input  logic [1:0]           row,
    input  logic [4:0]           column,
    output logic                 push,
    output lcdnw_pkg::cmd_t      cmd,
    output logic                 init_done
);

    logic       init_done_reg;
    logic       init_done_next;
    logic       cursor_ok;
    logic [7:0] cursor_code;

    assign cursor_ok   = ({1'b0, row} < 3'(ROWS)) && ({1'b0, column} < 6'(COLUMNS));
    assign cursor_code = (8'({row, {lcdnw_pkg::ROW_SHIFT{1'b0}}}) + {3'b000, column})
                       | lcdnw_pkg::CMD_SET_DDRAM;

    always_comb begin
        cmd  = '0;
        push = accept;
        unique case (lcdnw_pkg::op_t'(operation))
            lcdnw_pkg::OP_DATA: begin
                cmd.rs   = 1'b1;
                cmd.full = 1'b1;
                cmd.code = value;
            end
            lcdnw_pkg::OP_INSTR: begin
                cmd.full = init_done_reg;
                cmd.code = value;
            end
            lcdnw_pkg::OP_CURSOR: begin
                cmd.full = init_done_reg;
                cmd.code = cursor_code;
                push     = accept && cursor_ok;
            end
            default: begin
                cmd.is_init = 1'b1;
            end
        endcase
    end

    assign init_done_next = init_done_reg
                         || (accept && (operation == lcdnw_pkg::OP_INIT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_done_reg <= 1'b0;
        end else begin
            init_done_reg <= init_done_next;
        end
    end

    assign init_done = init_done_reg;

endmodule

>>> rtl/core/lcdnw_queue.sv
// Short command queue between the front classifier and the strobe sequencer.
// Depends on lcdnw_pkg.
module lcdnw_queue (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  lcdnw_pkg::cmd_t           wr_cmd,
    input  logic                      pop,
    output lcdnw_pkg::cmd_t           rd_cmd,
    output lcdnw_pkg::queue_status_t  status,
    output logic [lcdnw_pkg::QUEUE_CW-1:0] count
);

    lcdnw_pkg::cmd_t                   mem_reg [lcdnw_pkg::QUEUE_DEPTH];
    logic [lcdnw_pkg::QUEUE_AW-1:0]    wr_ptr_reg;
    logic [lcdnw_pkg::QUEUE_AW-1:0]    wr_ptr_next;
    logic [lcdnw_pkg::QUEUE_AW-1:0]    rd_ptr_reg;
    logic [lcdnw_pkg::QUEUE_AW-1:0]    rd_ptr_next;
    logic [lcdnw_pkg::QUEUE_CW-1:0]    count_reg;
    logic [lcdnw_pkg::QUEUE_CW-1:0]    count_next;
    logic                              do_push;
    logic                              do_pop;

    assign status.full  = (count_reg == lcdnw_pkg::QUEUE_CW'(lcdnw_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    assign rd_cmd = mem_reg[rd_ptr_reg];
    assign count  = count_reg;

endmodule

>>> rtl/core/lcdnw_back.sv
// Strobe sequencer: expands the head command into enable strobes, one per cycle unless the result channel stalls.
// Depends on lcdnw_pkg; drives the registered result channel.
module lcdnw_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  lcdnw_pkg::cmd_t           cmd,
    input  lcdnw_pkg::queue_status_t  status,
    output logic                      pop,
    input  logic [7:0]                strobe_ms,
    input  logic [7:0]                settle_ms,
    input  logic [7:0]                power_up_ms,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output lcdnw_pkg::strobe_t        m_strobe,
    output logic                      m_last,
    output logic [2:0]                step
);

    logic                  valid_reg;
    logic                  valid_next;
    lcdnw_pkg::strobe_t    data_reg;
    logic                  last_reg;
    logic [2:0]            step_reg;
    logic [2:0]            step_next;
    logic                  emit;
    lcdnw_pkg::strobe_t    strobe;
    logic                  strobe_last;

    assign emit = !status.empty && (!valid_reg || m_tready);

    always_comb begin
        strobe            = '0;
        strobe.pulse_ms   = (strobe_ms == '0) ? 8'd1 : strobe_ms;
        strobe.reg_select = cmd.rs;
        strobe_last       = 1'b1;
        if (cmd.is_init) begin
            strobe.reg_select = 1'b0;
            strobe.nibble     = lcdnw_pkg::init_nibble(step_reg);
            strobe.lead_ms    = (step_reg == '0) ? power_up_ms : 8'd0;
            strobe.after_ms   = {1'b0, settle_ms}
                              + {7'b0, lcdnw_pkg::init_extra(step_reg)};
            strobe_last       = (step_reg == lcdnw_pkg::INIT_LAST_STEP);
        end else if (cmd.full && (step_reg == '0)) begin
            strobe.nibble   = cmd.code[7:4];
            strobe.after_ms = 9'd0;
            strobe_last     = 1'b0;
        end else if (cmd.full) begin
            strobe.nibble   = cmd.code[3:0];
            strobe.after_ms = {1'b0, settle_ms};
        end else begin
            strobe.nibble   = cmd.code[7:4];
            strobe.after_ms = {1'b0, settle_ms};
        end
    end

    always_comb begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (emit) begin
            valid_next = 1'b1;
            step_next  = strobe_last ? 3'd0 : step_reg + 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    assign pop = emit && strobe_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            data_reg <= strobe;
            last_reg <= strobe_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_strobe = data_reg;
    assign m_last   = last_reg;
    assign step     = step_reg;

endmodule

>>> rtl/core/char_lcd_nibble_writer_core.sv
// Character LCD 4-bit bus writer: requests in, one result per enable strobe out.
// Depends on lcdnw_pkg, lcdnw_front, lcdnw_queue and lcdnw_back.
//
// A request is taken whenever the four-entry command queue has room; the sequencer
// then issues one strobe result per cycle from the queue head while the result channel
// is not stalled, so a request yields one result (instruction or cursor move before an
// init request is taken), two (full byte) or seven (init sequence); an out-of-range
// cursor move produces nothing. The result register is refilled in the same cycle it
// is taken. Configuration writes take effect on the next clock.
module char_lcd_nibble_writer_core #(
    parameter int ROWS    = 2,
    parameter int COLUMNS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // value[7:0], row[9:8], column[14:10], zero[15]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // reg_select[0], nibble[4:1], lead_ms[12:5],
                                   // pulse_ms[20:13], after_ms[29:21], zero[31:30]
    output logic        m_tlast
);

    logic [7:0]                         strobe_ms_reg;
    logic [7:0]                         settle_ms_reg;
    logic [7:0]                         power_up_ms_reg;
    logic                               accept;
    logic                               push;
    logic                               pop;
    logic                               init_done;
    lcdnw_pkg::cmd_t                    wr_cmd;
    lcdnw_pkg::cmd_t                    rd_cmd;
    lcdnw_pkg::queue_status_t           status;
    logic [lcdnw_pkg::QUEUE_CW-1:0]     count;
    lcdnw_pkg::strobe_t                 m_strobe;
    logic [2:0]                         step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strobe_ms_reg   <= lcdnw_pkg::STROBE_RESET;
            settle_ms_reg   <= lcdnw_pkg::SETTLE_RESET;
            power_up_ms_reg <= lcdnw_pkg::POWER_UP_RESET;
        end else if (cfg_we) begin
            priority case (cfg_index)
                lcdnw_pkg::CFG_STROBE:   strobe_ms_reg   <= cfg_wdata;
                lcdnw_pkg::CFG_SETTLE:   settle_ms_reg   <= cfg_wdata;
                lcdnw_pkg::CFG_POWER_UP: power_up_ms_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_tready = !status.full;
    assign accept   = s_tvalid && s_tready;

    lcdnw_front #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .operation (s_tuser),
        .value     (s_tdata[7:0]),
        .row       (s_tdata[9:8]),
        .column    (s_tdata[14:10]),
        .push      (push),
        .cmd       (wr_cmd),
        .init_done (init_done)
    );

    lcdnw_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_cmd  (wr_cmd),
        .pop     (pop),
        .rd_cmd  (rd_cmd),
        .status  (status),
        .count   (count)
    );

    lcdnw_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (rd_cmd),
        .status      (status),
        .pop         (pop),
        .strobe_ms   (strobe_ms_reg),
        .settle_ms   (settle_ms_reg),
        .power_up_ms (power_up_ms_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_strobe    (m_strobe),
        .m_last      (m_tlast),
        .step        (step)
    );

    assign m_tdata = {2'b00, m_strobe};

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count <= lcdnw_pkg::QUEUE_CW'(lcdnw_pkg::QUEUE_DEPTH))
        else $error("command queue count beyond depth");

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        step <= lcdnw_pkg::INIT_LAST_STEP)
        else $error("strobe step beyond init sequence");

    a_init_sets_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_tuser == lcdnw_pkg::OP_INIT)) |=> init_done)
        else $error("init request did not set init_done");

    a_pulse_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_strobe.pulse_ms != 8'd0))
        else $error("zero enable pulse length");

endmodule

>>> sim/testbench.sv
// Self-checking testbench for char_lcd_nibble_writer_core: random and directed LCD requests
// go in, each enable strobe result is compared against an in-bench model of the 4-bit writer.
// Depends on lcdnw_pkg and the RTL of the core.
module testbench;

    localparam int         ROWS       = 2;
    localparam int         COLUMNS    = 16;
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int         PHASE_RAND = 50;
    localparam int         DRAIN_CYC  = 24;
    // init nibbles 2,2,8,0,C,0,1 and extra settle 0,0,1,0,1,0,2, step 0 in the low bits
    localparam logic [27:0] INIT_NIBS  = 28'h10C0822;
    localparam logic [13:0] INIT_EXTRA = 14'h2110;

    typedef struct packed {
        lcdnw_pkg::op_t op;
        logic [7:0]     value;
        logic [1:0]     row;
        logic [4:0]     column;
    } lcd_req_t;

    typedef struct packed {
        lcdnw_pkg::strobe_t strobe;
        logic               last;
    } strobe_rec_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = lcdnw_pkg::CFG_STROBE;
    logic [7:0]  cfg_wdata = 8'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'd0;   // value[7:0], row[9:8], column[14:10], zero[15]
    logic [1:0]  s_tuser = lcdnw_pkg::OP_DATA; // operation[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // reg_select[0], nibble[4:1], lead_ms[12:5],
                                    // pulse_ms[20:13], after_ms[29:21], zero[31:30]
    logic        m_tlast;

    lcd_req_t    lcd_requests[$];
    strobe_rec_t pending_strobes[$];
    lcd_req_t    on_bus;

    logic [7:0]  strobe_reg = lcdnw_pkg::STROBE_RESET;
    logic [7:0]  settle_reg = lcdnw_pkg::SETTLE_RESET;
    logic [7:0]  power_reg  = lcdnw_pkg::POWER_UP_RESET;
    logic        lcd_ready  = 1'b0;

    int burst_left = 0;
    int gap_left = 0;
    int rx_tick = 0;
    int rx_mode = 0;
    int bad_strobes = 0;
    int strobes_checked = 0;
    int dropped_moves = 0;
    int op_count[4] = '{0, 0, 0, 0};

    char_lcd_nibble_writer_core #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void queue_strobe(logic rs, logic [3:0] nib, logic [7:0] lead,
                                         logic [8:0] after, logic last);
        strobe_rec_t rec;
        rec.strobe.reg_select = rs;
        rec.strobe.nibble     = nib;
        rec.strobe.lead_ms    = lead;
        rec.strobe.pulse_ms   = (strobe_reg == 8'd0) ? 8'd1 : strobe_reg;
        rec.strobe.after_ms   = after;
        rec.last              = last;
        pending_strobes.push_back(rec);
    endfunction

    function automatic void queue_byte(logic rs, logic [7:0] code, logic full);
        if (!full) begin
            queue_strobe(rs, code[7:4], 8'd0, {1'b0, settle_reg}, 1'b1);
        end else begin
            queue_strobe(rs, code[7:4], 8'd0, 9'd0, 1'b0);
            queue_strobe(rs, code[3:0], 8'd0, {1'b0, settle_reg}, 1'b1);
        end
    endfunction

    function automatic void forecast_strobes(lcd_req_t r);
        logic [7:0] code;
        op_count[r.op]++;
        case (r.op)
            lcdnw_pkg::OP_DATA: begin
                queue_byte(1'b1, r.value, 1'b1);
            end
            lcdnw_pkg::OP_INSTR: begin
                queue_byte(1'b0, r.value, lcd_ready);
            end
            lcdnw_pkg::OP_CURSOR: begin
                if (r.row >= ROWS || r.column >= COLUMNS) begin
                    dropped_moves++;
                end else begin
                    code = lcdnw_pkg::CMD_SET_DDRAM
                         | ((8'(r.row) << lcdnw_pkg::ROW_SHIFT) + 8'(r.column));
                    queue_byte(1'b0, code, lcd_ready);
                end
            end
            default: begin
                for (int k = 0; k < 7; k++) begin
                    queue_strobe(1'b0, INIT_NIBS[4*k +: 4], (k == 0) ? power_reg : 8'd0,
                                 {1'b0, settle_reg} + 9'(INIT_EXTRA[2*k +: 2]), k == 6);
                end
                lcd_ready = 1'b1;
            end
        endcase
    endfunction

    function automatic lcd_req_t random_request();
        lcd_req_t r;
        int pick;
        pick     = $urandom_range(0, 99);
        r.value  = 8'($urandom_range(0, 255));
        r.row    = 2'($urandom_range(0, 3));
        r.column = 5'($urandom_range(0, 31));
        if (pick < 30) begin
            r.op = lcdnw_pkg::OP_DATA;
        end else if (pick < 60) begin
            r.op = lcdnw_pkg::OP_INSTR;
        end else if (pick < 88) begin
            r.op = lcdnw_pkg::OP_CURSOR;
            if ($urandom_range(0, 3) != 0) begin
                r.row    = 2'($urandom_range(0, ROWS - 1));
                r.column = 5'($urandom_range(0, COLUMNS - 1));
            end
        end else begin
            r.op = lcdnw_pkg::OP_INIT;
        end
        return r;
    endfunction

    task automatic add_request(lcdnw_pkg::op_t op, logic [7:0] value, logic [1:0] row,
                               logic [4:0] column);
        lcd_req_t r;
        r.op     = op;
        r.value  = value;
        r.row    = row;
        r.column = column;
        lcd_requests.push_back(r);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            lcdnw_pkg::CFG_STROBE:   strobe_reg = val;
            lcdnw_pkg::CFG_SETTLE:   settle_reg = val;
            lcdnw_pkg::CFG_POWER_UP: power_reg  = val;
            default:      ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (lcd_requests.size() != 0 || s_tvalid || pending_strobes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    task automatic add_random(int count);
        repeat (count) lcd_requests.push_back(random_request());
    endtask

    // request driver: bursts of random length separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                forecast_strobes(on_bus);
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (lcd_requests.size() > 0) begin
                    on_bus = lcd_requests.pop_front();
                    s_tuser  <= on_bus.op;
                    s_tdata  <= {1'b0, on_bus.column, on_bus.row, on_bus.value};
                    s_tvalid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 12);
                    end
                    burst_left--;
                    if (burst_left == 0) begin
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result backpressure: the stall mode is redrawn at random from four modes
    always @(posedge aclk) begin
        rx_tick++;
        if (rx_tick % 48 == 0) begin
            rx_mode = $urandom_range(0, 3);
        end
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (rx_tick % 5 != 0);
            default: m_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // strobe monitor
    always @(posedge aclk) begin
        lcdnw_pkg::strobe_t got;
        strobe_rec_t        want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[29:0];
            strobes_checked++;
            if (pending_strobes.size() == 0) begin
                if (bad_strobes < 10) begin
                    $display({"unexpected strobe: rs=%0d nib=%h lead=%0d pulse=%0d",
                              " after=%0d last=%0d"},
                             got.reg_select, got.nibble, got.lead_ms, got.pulse_ms,
                             got.after_ms, m_tlast);
                end
                bad_strobes++;
            end else begin
                want = pending_strobes.pop_front();
                if (got.reg_select != want.strobe.reg_select ||
                    got.nibble     != want.strobe.nibble ||
                    got.lead_ms    != want.strobe.lead_ms ||
                    got.pulse_ms   != want.strobe.pulse_ms ||
                    got.after_ms   != want.strobe.after_ms ||
                    m_tlast        != want.last) begin
                    if (bad_strobes < 10) begin
                        $display({"strobe %0d expected rs=%0d nib=%h lead=%0d pulse=%0d",
                                  " after=%0d last=%0d"},
                                 strobes_checked, want.strobe.reg_select, want.strobe.nibble,
                                 want.strobe.lead_ms, want.strobe.pulse_ms,
                                 want.strobe.after_ms, want.last);
                        $display({"strobe %0d actual   rs=%0d nib=%h lead=%0d pulse=%0d",
                                  " after=%0d last=%0d"},
                                 strobes_checked, got.reg_select, got.nibble, got.lead_ms,
                                 got.pulse_ms, got.after_ms, m_tlast);
                    end
                    bad_strobes++;
                end
            end
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // half-instruction mode, then init, then full bytes
        add_request(lcdnw_pkg::OP_INSTR,  8'h00, 2'd3, 5'd31);
        add_request(lcdnw_pkg::OP_INSTR,  8'hFF, 2'd0, 5'd0);
        add_request(lcdnw_pkg::OP_CURSOR, 8'hA5, 2'd0, 5'd0);
        add_request(lcdnw_pkg::OP_CURSOR, 8'h5A, 2'd1, 5'd15);
        add_request(lcdnw_pkg::OP_CURSOR, 8'h00, 2'd2, 5'd0);
        add_request(lcdnw_pkg::OP_DATA,   8'h00, 2'd0, 5'd0);
        add_request(lcdnw_pkg::OP_DATA,   8'hFF, 2'd3, 5'd31);
        add_request(lcdnw_pkg::OP_INIT,   8'hFF, 2'd3, 5'd31);
        add_request(lcdnw_pkg::OP_INSTR,  8'h28, 2'd0, 5'd0);
        add_request(lcdnw_pkg::OP_INSTR,  8'hFF, 2'd1, 5'd16);
        add_request(lcdnw_pkg::OP_CURSOR, 8'hFF, 2'd0, 5'd15);
        add_request(lcdnw_pkg::OP_CURSOR, 8'h00, 2'd1, 5'd0);
        add_request(lcdnw_pkg::OP_CURSOR, 8'h00, 2'd3, 5'd5);
        add_request(lcdnw_pkg::OP_CURSOR, 8'h00, 2'd0, 5'd16);
        add_request(lcdnw_pkg::OP_CURSOR, 8'h00, 2'd1, 5'd31);
        add_request(lcdnw_pkg::OP_DATA,   8'hA5, 2'd2, 5'd10);
        add_request(lcdnw_pkg::OP_INIT,   8'h00, 2'd0, 5'd0);
        add_request(lcdnw_pkg::OP_DATA,   8'h5A, 2'd1, 5'd21);
        add_random(PHASE_RAND);
        drain();

        write_reg(lcdnw_pkg::CFG_STROBE, 8'd255);
        write_reg(lcdnw_pkg::CFG_SETTLE, 8'd255);
        write_reg(lcdnw_pkg::CFG_POWER_UP, 8'd255);
        add_request(lcdnw_pkg::OP_INIT, 8'h00, 2'd0, 5'd0);
        add_random(PHASE_RAND);
        drain();

        write_reg(lcdnw_pkg::CFG_STROBE, 8'd0);
        write_reg(lcdnw_pkg::CFG_SETTLE, 8'd0);
        write_reg(lcdnw_pkg::CFG_POWER_UP, 8'd0);
        write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
        add_request(lcdnw_pkg::OP_INIT, 8'h00, 2'd0, 5'd0);
        add_random(PHASE_RAND);
        drain();

        write_reg(lcdnw_pkg::CFG_STROBE, 8'($urandom_range(1, 254)));
        write_reg(lcdnw_pkg::CFG_SETTLE, 8'($urandom_range(1, 254)));
        write_reg(lcdnw_pkg::CFG_POWER_UP, 8'($urandom_range(1, 254)));
        write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
        add_random(PHASE_RAND);
        drain();

        if (pending_strobes.size() != 0) begin
            $display("%0d expected strobes never arrived", pending_strobes.size());
            bad_strobes += pending_strobes.size();
        end
        $display("requests: %0d data, %0d instruction, %0d cursor (%0d off-screen), %0d init",
                 op_count[lcdnw_pkg::OP_DATA], op_count[lcdnw_pkg::OP_INSTR],
                 op_count[lcdnw_pkg::OP_CURSOR], dropped_moves,
                 op_count[lcdnw_pkg::OP_INIT]);
        $display("strobes checked: %0d over four register settings, mismatches: %0d",
                 strobes_checked, bad_strobes);
        if (bad_strobes == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout waiting for strobes");
        $display("testbench: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/lcdnw_pkg.sv
rtl/core/lcdnw_front.sv
rtl/core/lcdnw_queue.sv
rtl/core/lcdnw_back.sv
rtl/core/char_lcd_nibble_writer_core.sv
sim/testbench.sv
